// ----- rtl/core/sgd_pkg.sv -----
// Shared types, constants and helpers for the supersample Gaussian downsampler.
// Used by every module of the core and by its port checker; depends on nothing.
package sgd_pkg;

	localparam int SGD_MAX_PIXELS = 1024;
	localparam int SGD_MAX_LINES = 4096;

	localparam int SGD_PPL_W = 11;
	localparam logic [SGD_PPL_W-1:0] SGD_PPL_RESET = 11'd1024;

	localparam int SGD_ROW_TOP = 4 * SGD_MAX_LINES - 1;
	localparam int SGD_ROW_W = $clog2(SGD_ROW_TOP + 1);
	localparam int SGD_RTH_W = $clog2(SGD_ROW_TOP / 3 + 1);
	localparam int SGD_OUT_ROW_TOP = SGD_MAX_LINES - 1;

	localparam int SGD_LINES = 6;
	localparam int SGD_TAPS = 7;

	localparam logic [7:0] SGD_WEIGHT [SGD_TAPS] = '{8'd4, 8'd22, 8'd60, 8'd84, 8'd60, 8'd22, 8'd4};

	typedef logic [2:0][7:0] sgd_rgb_t;
	typedef logic [2:0][15:0] sgd_vsum_t;
	typedef logic [2:0][23:0] sgd_part_t;

	typedef struct packed {
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
		logic frame_start;
	} sgd_sample_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic [9:0] pixel_column;
		logic [11:0] pixel_row;
		logic row_end;
	} sgd_pixel_t;

	// Maps a tap position to the line bank that holds it, given the bank of the current row.
	function automatic logic [2:0] sgd_slot(input logic [2:0] base, input logic [2:0] k);
		logic [3:0] s;
		s = {1'b0, base} + {1'b0, k};
		return (s >= 4'd6) ? 3'(s - 4'd6) : 3'(s);
	endfunction

endpackage

// ----- rtl/core/supersample_gaussian_downsampler_core.sv -----
// The block accepts one subsample per cycle unless the input is stalled and delivers a
// filtered pixel via registered line store read, vertical sum and output stages. Six
// line banks of 3*MAX_PIXELS+4 entries; each access writes one and reads all six.
// Two finished pixels can wait at the output; the input stalls only then.
module supersample_gaussian_downsampler_core
	import sgd_pkg::*;
#(
	parameter int MAX_PIXELS = SGD_MAX_PIXELS
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic [SGD_PPL_W-1:0] cfg_wr_data,
	input logic sample_valid,
	output logic sample_stall,
	input sgd_sample_t sample,
	output logic pixel_valid,
	input logic pixel_stall,
	output sgd_pixel_t pixel
);

	localparam int DEPTH = 3 * MAX_PIXELS + 4;
	localparam int CW = $clog2(DEPTH);

	logic [SGD_PPL_W-1:0] ppl_q;
	logic [CW-1:0] col_q, th_q;
	logic [1:0] ph_q;
	logic [SGD_ROW_W-1:0] row_q;
	logic [2:0] rm6_q;
	logic [SGD_RTH_W-1:0] rth_q;

	logic en, accept;
	logic [SGD_PPL_W-1:0] n_raw;
	logic [CW-1:0] n_c, last, c0, th0, c_cur, th_cur, p_full;
	logic [1:0] ph0, ph_cur;
	logic line_end, out_row, col_hit;
	logic [SGD_ROW_W-1:0] r0;
	logic [2:0] rm6_0;
	logic [SGD_RTH_W-1:0] rth0, orow_full;
	logic [11:0] orow_cur;
	sgd_rgb_t cur;

	logic vld_s1, emit_s1, rend_s1;
	sgd_rgb_t cur_s1;
	sgd_rgb_t [SGD_LINES-1:0] rd_s1;
	logic [2:0] rm6_s1;
	logic [9:0] p_s1;
	logic [11:0] orow_s1;
	sgd_vsum_t vacc;

	logic vld_s2, shift_s2, emit_s2, rend_s2;
	sgd_vsum_t vs_s2;
	logic [9:0] p_s2;
	logic [11:0] orow_s2;
	logic out_row_s1;

	sgd_part_t part [SGD_LINES];
	sgd_part_t hsum;
	logic chain_shift, res_new;
	sgd_pixel_t res, o_q, k_q;
	logic o_vld_q, k_vld_q;

	assign en = !k_vld_q;
	assign sample_stall = k_vld_q;
	assign accept = sample_valid && en;
	assign cur = {sample.red_in, sample.green_in, sample.blue_in};

	always_comb begin
		n_raw = (ppl_q == '0) ? SGD_PPL_W'(1) : ppl_q;
		n_c = (32'(n_raw) > MAX_PIXELS) ? CW'(MAX_PIXELS) : CW'(n_raw);
		last = (n_c << 1) + n_c + CW'(3);
		c0 = sample.frame_start ? '0 : col_q;
		ph0 = sample.frame_start ? '0 : ph_q;
		th0 = sample.frame_start ? '0 : th_q;
		line_end = (c0 >= last);
		c_cur = line_end ? last : c0;
		ph_cur = line_end ? 2'd0 : ph0;
		th_cur = line_end ? n_c + CW'(1) : th0;
		col_hit = (ph_cur == 2'd0) && (th_cur >= CW'(2)) && (th_cur < n_c + CW'(2));
		p_full = th_cur - CW'(2);
		r0 = sample.frame_start ? '0 : row_q;
		rm6_0 = sample.frame_start ? '0 : rm6_q;
		rth0 = sample.frame_start ? '0 : rth_q;
		out_row = (rth0 >= SGD_RTH_W'(2)) && (rm6_0 == 3'd0 || rm6_0 == 3'd3);
		orow_full = rth0 - SGD_RTH_W'(2);
		orow_cur = (orow_full > SGD_RTH_W'(SGD_OUT_ROW_TOP)) ? 12'(SGD_OUT_ROW_TOP)
			: 12'(orow_full);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppl_q <= SGD_PPL_RESET;
			col_q <= '0;
			ph_q <= '0;
			th_q <= '0;
			row_q <= '0;
			rm6_q <= '0;
			rth_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				ppl_q <= cfg_wr_data;
			end
			if (accept) begin
				row_q <= r0;
				rm6_q <= rm6_0;
				rth_q <= rth0;
				if (line_end) begin
					col_q <= '0;
					ph_q <= '0;
					th_q <= '0;
					if (32'(r0) < SGD_ROW_TOP) begin
						row_q <= r0 + SGD_ROW_W'(1);
						rm6_q <= (rm6_0 == 3'd5) ? 3'd0 : rm6_0 + 3'd1;
						if (rm6_0 == 3'd2 || rm6_0 == 3'd5) begin
							rth_q <= rth0 + SGD_RTH_W'(1);
						end
					end
				end else begin
					col_q <= c_cur + CW'(1);
					ph_q <= (ph_cur == 2'd2) ? 2'd0 : ph_cur + 2'd1;
					th_q <= (ph_cur == 2'd2) ? th_cur + CW'(1) : th_cur;
				end
			end
		end
	end

	sgd_line_store #(
		.DEPTH(DEPTH),
		.AW(CW)
	) u_line_store (
		.clk(clk),
		.access(accept),
		.bank(rm6_0),
		.addr(c_cur),
		.wdata(cur),
		.rdata(rd_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_s1 <= cur;
			rm6_s1 <= rm6_0;
			out_row_s1 <= out_row;
			emit_s1 <= out_row && col_hit;
			p_s1 <= 10'(p_full);
			orow_s1 <= orow_cur;
			rend_s1 <= (th_cur == n_c + CW'(1));
		end
		if (en) begin
			vs_s2 <= vacc;
			shift_s2 <= out_row_s1;
			emit_s2 <= emit_s1;
			p_s2 <= p_s1;
			orow_s2 <= orow_s1;
			rend_s2 <= rend_s1;
		end
	end

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			vacc[ch] = 16'(SGD_WEIGHT[SGD_TAPS-1]) * 16'(cur_s1[ch]);
			for (int k = 0; k < SGD_LINES; k++) begin
				vacc[ch] = vacc[ch] + 16'(SGD_WEIGHT[k])
					* 16'(rd_s1[sgd_slot(rm6_s1, 3'(k))][ch]);
			end
		end
	end

	assign chain_shift = en && vld_s2 && shift_s2;

	for (genvar g = 0; g < SGD_LINES; g++) begin : g_cell
		sgd_tap_cell #(
			.WEIGHT(int'(SGD_WEIGHT[g+1]))
		) u_cell (
			.clk(clk),
			.shift(chain_shift),
			.x(vs_s2),
			.part_in((g == SGD_LINES - 1) ? sgd_part_t'('0) : part[(g+1) % SGD_LINES]),
			.part_q(part[g])
		);
	end

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			hsum[ch] = part[0][ch] + 24'(SGD_WEIGHT[0]) * 24'(vs_s2[ch]);
		end
		res.red_out = hsum[2][23:16];
		res.green_out = hsum[1][23:16];
		res.blue_out = hsum[0][23:16];
		res.pixel_column = p_s2;
		res.pixel_row = orow_s2;
		res.row_end = rend_s2;
	end

	assign res_new = en && vld_s2 && emit_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_vld_q <= 1'b0;
			k_vld_q <= 1'b0;
		end else if (k_vld_q) begin
			if (!pixel_stall) begin
				k_vld_q <= 1'b0;
			end
		end else if (res_new) begin
			if (o_vld_q && pixel_stall) begin
				k_vld_q <= 1'b1;
			end else begin
				o_vld_q <= 1'b1;
			end
		end else if (!pixel_stall) begin
			o_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (k_vld_q) begin
			if (!pixel_stall) begin
				o_q <= k_q;
			end
		end else if (res_new) begin
			if (o_vld_q && pixel_stall) begin
				k_q <= res;
			end else begin
				o_q <= res;
			end
		end
	end

	assign pixel_valid = o_vld_q;
	assign pixel = o_q;

endmodule

// ----- rtl/core/sgd_line_store.sv -----
// Six banks of subsample line memory with one shared address.
// Depends on sgd_pkg; one bank is written and all six are read per access.
module sgd_line_store
	import sgd_pkg::*;
#(
	parameter int DEPTH = 3 * SGD_MAX_PIXELS + 4,
	parameter int AW = $clog2(3 * SGD_MAX_PIXELS + 4)
) (
	input logic clk,
	input logic access,
	input logic [2:0] bank,
	input logic [AW-1:0] addr,
	input sgd_rgb_t wdata,
	output sgd_rgb_t [SGD_LINES-1:0] rdata
);

	for (genvar b = 0; b < SGD_LINES; b++) begin : g_bank
		sgd_rgb_t mem [DEPTH];

		always_ff @(posedge clk) begin
			if (access) begin
				rdata[b] <= mem[addr];
				if (bank == 3'(b)) begin
					mem[addr] <= wdata;
				end
			end
		end
	end

endmodule

// ----- rtl/core/sgd_tap_cell.sv -----
// One cell of the horizontal transposed filter chain.
// Depends on sgd_pkg; adds its weighted column sum to the partial sum from its neighbor.
module sgd_tap_cell
	import sgd_pkg::*;
#(
	parameter int WEIGHT = 4
) (
	input logic clk,
	input logic shift,
	input sgd_vsum_t x,
	input sgd_part_t part_in,
	output sgd_part_t part_q
);

	always_ff @(posedge clk) begin
		if (shift) begin
			for (int ch = 0; ch < 3; ch++) begin
				part_q[ch] <= part_in[ch] + 24'(x[ch]) * 24'(WEIGHT);
			end
		end
	end

endmodule

// ----- rtl/core/sgd_checker.sv -----
// Port checker for the supersample Gaussian downsampler core, bound to the top level.
// Depends on sgd_pkg and on the port names of the core.
module sgd_checker
	import sgd_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic sample_valid,
	input logic sample_stall,
	input logic pixel_valid,
	input logic pixel_stall,
	input sgd_pixel_t pixel
);

	// A stalled request on the output keeps its payload.
	a_pixel_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && pixel_stall |=> pixel_valid && $stable(pixel))
		else $error("pixel request changed while stalled");

	// The input only stalls while a pixel is waiting at the output.
	a_stall_needs_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> pixel_valid)
		else $error("input stalled with no pixel waiting");

	// The input stall can only follow a stalled output request.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall && sample_valid |-> $past(pixel_valid && pixel_stall))
		else $error("input stalled without output backpressure");

	// Once a pixel is taken, the input is free again in the next cycle.
	a_stall_release: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && !pixel_stall |=> !sample_stall)
		else $error("input still stalled after the output drained");

endmodule

bind supersample_gaussian_downsampler_core sgd_checker u_sgd_checker (.*);
